### design/bscs_pkg.sv
// Package for bounded_sequence_sum_count: field widths, the prime modulus,
// the controller state type and the modular add helper.
// No dependencies.
package bscs_pkg;

  localparam int SEQ_LEN_W  = 7;
  localparam int PART_MAX_W = 13;
  localparam int SUM_MAX_W  = 13;
  localparam int COUNT_W    = 30;

  localparam logic [COUNT_W-1:0] MODULUS = COUNT_W'(998244353);

  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // Add two residues; both are below the modulus, so one subtract corrects.
  function automatic count_t mod_add(input count_t a, input count_t b);
    logic [COUNT_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, MODULUS}) begin
        s = s - {1'b0, MODULUS};
      end
      mod_add = s[COUNT_W-1:0];
    end
  endfunction

endpackage

### design/bscs_ram.sv
// Generic synchronous RAM for bounded_sequence_sum_count: one write port,
// two read ports, read data registered. No dependencies.
module bscs_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4097
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry when enabled, read two entries, every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### design/bounded_sequence_sum_count.sv
// Top level of bounded_sequence_sum_count: row-by-row table build over two
// ping-pong row memories with a sliding window sum. Uses bscs_pkg, bscs_ram.
//
//   channel | direction | ports                                    | accepted when
//   in      | input     | in_seq_len, in_part_max, in_sum_max      | in_valid && !in_stall
//   out     | output    | out_count_mod                            | out_valid && !out_stall
//
// A request with n >= 2 valid elements builds its table one cell per cycle through
// the window update loop, set by the single write port of each row memory, then
// drains the read and accumulate stages, loads the result register and returns to
// idle, where the next request is taken. Trivial requests go from acceptance
// straight to the result load.
// One request is in work at a time; the result register lets a new request
// enter while the previous result is still stalled at the output.
// rst_n is synchronous and clears control state only; row memories start
// undefined and every entry whose value is used is written before it is read.
module bounded_sequence_sum_count #(
  parameter int MAX_LEN = 64,
  parameter int MAX_SUM = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bscs_pkg::SEQ_LEN_W-1:0]    in_seq_len,
  input  logic [bscs_pkg::PART_MAX_W-1:0]   in_part_max,
  input  logic [bscs_pkg::SUM_MAX_W-1:0]    in_sum_max,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bscs_pkg::COUNT_W-1:0]      out_count_mod
);

  import bscs_pkg::*;

  localparam int AW = $clog2(MAX_SUM + 1);
  localparam int RW = $clog2(MAX_LEN + 1);

  state_t state_r, state_nxt;

  // request registers
  logic [RW-1:0] n_r;
  logic [AW-1:0] m_r, k_r;

  // issue counters
  logic [RW-1:0] row_r;
  logic [AW-1:0] col_r;

  // read stage
  logic          v1_r;
  logic [AW-1:0] j1_r;
  logic [RW-1:0] row1_r;
  logic          a_en1_r, b_en1_r;
  logic [AW-1:0] addr_a1_r, addr_b1_r;

  // window and answer
  count_t w_r, w_nxt;
  logic   accv_r;
  count_t acc_r, res_r;

  logic   out_valid_r;
  count_t out_count_r;

  // clipped request fields
  logic [RW-1:0] n_sat;
  logic [AW-1:0] k_sat, m_sat;
  logic          trivial_zero, single_elem;
  logic          accept, load_out;

  // memory signals
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic          b_en_issue;
  count_t        b0_a, b0_b, b1_a, b1_b;
  count_t        val_a, val_b, mem_a, mem_b;
  logic          wr_en0, wr_en1;
  logic [31:0]   win_sum;

  assign in_stall      = (state_r != S_IDLE);
  assign accept        = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_count_mod = out_count_r;
  assign load_out      = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Clip the request fields to the table size (part limit to the sum limit) and flag trivial requests
  always_comb begin
    if (32'(in_seq_len) > 32'(MAX_LEN)) begin
      n_sat = RW'(MAX_LEN);
    end else begin
      n_sat = RW'(in_seq_len);
    end
    if (32'(in_sum_max) > 32'(MAX_SUM)) begin
      k_sat = AW'(MAX_SUM);
    end else begin
      k_sat = AW'(in_sum_max);
    end
    if (32'(in_part_max) > 32'(k_sat)) begin
      m_sat = k_sat;
    end else begin
      m_sat = AW'(in_part_max);
    end
    trivial_zero = (n_sat == '0) || (k_sat == '0) || (m_sat == '0) ||
                   (32'(n_sat) > 32'(k_sat));
    single_elem  = (n_sat == RW'(1));
  end

  // Read addresses for the current column: totals j-1 and j-m-1
  assign rd_addr_a  = col_r - AW'(1);
  assign rd_addr_b  = col_r - m_r - AW'(1);
  assign b_en_issue = ({1'b0, col_r} >= ({1'b0, m_r} + (AW+1)'(2)));

  // Row memories: even rows write bank 0, odd rows write bank 1
  assign wr_en0 = v1_r && !row1_r[0];
  assign wr_en1 = v1_r &&  row1_r[0];

  bscs_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_SUM + 1)) u_bank0 (
    .clk       (clk),
    .wr_en     (wr_en0),
    .wr_addr   (j1_r),
    .wr_data   (w_nxt),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (b0_a),
    .rd_data_b (b0_b)
  );

  bscs_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_SUM + 1)) u_bank1 (
    .clk       (clk),
    .wr_en     (wr_en1),
    .wr_addr   (j1_r),
    .wr_data   (w_nxt),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (b1_a),
    .rd_data_b (b1_b)
  );

  // Select the previous row: row 1 is generated, later rows come from memory
  always_comb begin
    mem_a = row1_r[0] ? b0_a : b1_a;
    mem_b = row1_r[0] ? b0_b : b1_b;
    if (row1_r == RW'(2)) begin
      val_a = ((addr_a1_r != '0) && (addr_a1_r <= m_r)) ? count_t'(1) : '0;
      val_b = ((addr_b1_r != '0) && (addr_b1_r <= m_r)) ? count_t'(1) : '0;
    end else begin
      val_a = mem_a;
      val_b = mem_b;
    end
    if (!a_en1_r) begin
      val_a = '0;
    end
    if (!b_en1_r) begin
      val_b = '0;
    end
  end

  // Slide the window: add the entering total, drop the leaving one
  always_comb begin
    win_sum = ((j1_r == AW'(1)) ? 32'd0 : 32'(w_r)) + 32'(val_a) - 32'(val_b);
    if (win_sum[31]) begin
      win_sum = win_sum + 32'(MODULUS);
    end else if (win_sum >= 32'(MODULUS)) begin
      win_sum = win_sum - 32'(MODULUS);
    end
    w_nxt = win_sum[COUNT_W-1:0];
  end

  // Advance the controller
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (trivial_zero || single_elem) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if ((col_r == k_r) && (row_r == n_r)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !accv_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      v1_r        <= 1'b0;
      accv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == S_RUN);
      accv_r  <= v1_r && (row1_r == n_r) && (32'(j1_r) >= 32'(n_r));
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // hold the request and start counters
    if (accept) begin
      n_r   <= n_sat;
      m_r   <= m_sat;
      k_r   <= k_sat;
      row_r <= RW'(2);
      col_r <= AW'(1);
      acc_r <= '0;
      if (trivial_zero) begin
        res_r <= '0;
      end else begin
        res_r <= count_t'(m_sat);
      end
    end else if (state_r == S_RUN) begin
      if (col_r == k_r) begin
        col_r <= AW'(1);
        if (row_r != n_r) begin
          row_r <= row_r + RW'(1);
        end
      end else begin
        col_r <= col_r + AW'(1);
      end
    end

    // issue stage to read stage
    j1_r      <= col_r;
    row1_r    <= row_r;
    a_en1_r   <= (col_r >= AW'(2));
    b_en1_r   <= b_en_issue;
    addr_a1_r <= rd_addr_a;
    addr_b1_r <= rd_addr_b;

    // window register
    if (v1_r) begin
      w_r <= w_nxt;
    end

    // accumulate the last row from its totals n .. k
    if (accv_r) begin
      acc_r <= mod_add(acc_r, w_r);
    end

    if ((state_r == S_DRAIN) && !v1_r && !accv_r) begin
      res_r <= acc_r;
    end

    if (load_out) begin
      out_count_r <= res_r;
    end
  end

endmodule

### test/testbench.sv
// Testbench for bounded_sequence_sum_count: drives count requests with random
// idling, predicts each count in a scoreboard class and checks every result.
// Depends on bscs_pkg and the bounded_sequence_sum_count RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEN_CAP     = 64;
  localparam int unsigned SUM_CAP     = 4096;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned STUCK_LIMIT = 1000000;
  localparam int unsigned SETTLE      = 16;

  // Predicted counts, oldest first, and the check against each result.
  class sequence_count_board;
    bscs_pkg::count_t expected_counts[$];
    int unsigned mismatches = 0;
    int unsigned last_row[SUM_CAP+1];
    int unsigned this_row[SUM_CAP+1];

    function int unsigned add_residue(int unsigned a, int unsigned b);
      int unsigned s;
      s = a + b;
      return (s >= bscs_pkg::MODULUS) ? s - bscs_pkg::MODULUS : s;
    endfunction

    // Count length-n sequences of parts 1..m with total at most k.
    function bscs_pkg::count_t count_sequences(int unsigned n, int unsigned m,
                                               int unsigned k);
      int unsigned span;
      int unsigned drop;
      int unsigned total;
      if (n > LEN_CAP) n = LEN_CAP;
      if (k > SUM_CAP) k = SUM_CAP;
      if (m > k) m = k;
      if (n == 0 || k == 0 || m == 0 || n > k) return '0;
      // one part: every total from 1 to m once
      for (int j = 0; j <= k; j++) last_row[j] = (j >= 1 && j <= m) ? 1 : 0;
      // add one part per row with a sliding window over the last m totals
      for (int r = 2; r <= n; r++) begin
        span = 0;
        this_row[0] = 0;
        for (int j = 1; j <= k; j++) begin
          if (j >= 2) span = add_residue(span, last_row[j-1]);
          if (j >= m + 2) begin
            drop = last_row[j-m-1];
            span = (span >= drop) ? span - drop : span + bscs_pkg::MODULUS - drop;
          end
          this_row[j] = span;
        end
        for (int j = 0; j <= k; j++) last_row[j] = this_row[j];
      end
      total = 0;
      for (int j = n; j <= k; j++) total = add_residue(total, last_row[j]);
      return bscs_pkg::count_t'(total);
    endfunction

    function void note_request(int unsigned n, int unsigned m, int unsigned k);
      expected_counts.push_back(count_sequences(n, m, k));
    endfunction

    function void check_result(bscs_pkg::count_t actual);
      bscs_pkg::count_t want;
      if (expected_counts.size() == 0) begin
        $error("count_mod: unexpected result, expected none, actual %0d", actual);
        mismatches++;
        return;
      end
      want = expected_counts.pop_front();
      if (actual !== want) begin
        $error("count_mod mismatch: expected %0d, actual %0d", want, actual);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [bscs_pkg::SEQ_LEN_W-1:0]  in_seq_len;
  logic [bscs_pkg::PART_MAX_W-1:0] in_part_max;
  logic [bscs_pkg::SUM_MAX_W-1:0]  in_sum_max;
  logic out_valid;
  logic out_stall;
  logic [bscs_pkg::COUNT_W-1:0]    out_count_mod;

  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int unsigned stuck_cycles = 0;
  sequence_count_board board = new();

  bounded_sequence_sum_count #(
    .MAX_LEN(LEN_CAP),
    .MAX_SUM(SUM_CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_seq_len(in_seq_len),
    .in_part_max(in_part_max),
    .in_sum_max(in_sum_max),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_count_mod(out_count_mod)
  );

  always #10 clk = ~clk;

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input int unsigned n, input int unsigned m,
                              input int unsigned k);
    in_valid    <= 1'b1;
    in_seq_len  <= n[bscs_pkg::SEQ_LEN_W-1:0];
    in_part_max <= m[bscs_pkg::PART_MAX_W-1:0];
    in_sum_max  <= k[bscs_pkg::SUM_MAX_W-1:0];
    do @(posedge clk); while (in_stall);
    board.note_request(n, m, k);
  endtask

  // Drop valid for a random burst now and then.
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted count has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Mostly small well-formed requests, some wider sums, some noise.
  task automatic send_random_request();
    int unsigned pick;
    int unsigned n;
    int unsigned m;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      k = $urandom_range(1, 64);
      n = $urandom_range(1, (k < 16) ? k : 16);
      m = $urandom_range(1, k + 8);
    end else if (pick < 85) begin
      k = $urandom_range(64, 600);
      n = $urandom_range(1, 4);
      m = $urandom_range(1, k);
    end else if (pick < 95) begin
      n = $urandom_range(0, 127);
      m = $urandom_range(0, 8191);
      k = $urandom_range(0, 40);
    end else begin
      n = $urandom_range(1, 2);
      m = $urandom_range(0, 8191);
      k = $urandom_range(0, 8191);
    end
    send_request(n, m, k);
  endtask

  // Result side: check each accepted count, then pick the next stall.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_result(out_count_mod);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when neither side moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_seq_len = '0;
    in_part_max = '0;
    in_sum_max = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, saturation, and the zero-count cases
    send_request(1, 1, 1);            sender_gap();
    send_request(0, 5, 10);           sender_gap();
    send_request(3, 0, 10);           sender_gap();
    send_request(3, 5, 0);            sender_gap();
    send_request(5, 3, 4);            sender_gap();
    send_request(127, 8191, 100);     sender_gap();
    send_request(2, 8191, 8191);      sender_gap();
    send_request(64, 4096, 4096);     sender_gap();
    send_request(1, 4096, 4096);      sender_gap();
    send_request(2, 1, 2);            sender_gap();
    send_request(4, 2, 8);            sender_gap();
    send_request(10, 100, 20);        sender_gap();
    send_request(64, 1, 64);          sender_gap();
    send_request(64, 2, 100);         sender_gap();
    send_request(7, 3, 15);           sender_gap();
    send_request(1, 5, 8191);         sender_gap();
    send_request(3, 4096, 4096);      sender_gap();
    send_request(64, 64, 64);         sender_gap();
    send_request(20, 4095, 63);       sender_gap();
    send_request(0, 0, 0);            sender_gap();

    // pause until the block is empty
    wait_for_results();

    // hold the result side off while short requests keep coming
    hold_request = 1'b1;
    repeat (6) begin
      send_request($urandom_range(2, 4), $urandom_range(1, 6), $urandom_range(4, 12));
    end

    // random requests; the tail runs without idling
    for (int i = 0; i < 74; i++) begin
      if (i == 60) quiet = 1'b1;
      send_random_request();
      sender_gap();
    end

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### files.f
design/bscs_pkg.sv
design/bscs_ram.sv
design/bounded_sequence_sum_count.sv
test/testbench.sv
